FILE: sv/cca_pkg.sv
package cca_pkg;

  localparam int YearBase = 1900;

  localparam int SecWidth   = 6;
  localparam int MinWidth   = 6;
  localparam int HourWidth  = 5;
  localparam int DayWidth   = 5;
  localparam int MonthWidth = 4;
  localparam int YearWidth  = 8;

  localparam int CalWidth = SecWidth + MinWidth + HourWidth + DayWidth + MonthWidth + YearWidth;
  localparam int InDataWidth  = ((CalWidth + 7) / 8) * 8;
  localparam int OutBits      = CalWidth + 4;
  localparam int OutDataWidth = ((OutBits + 7) / 8) * 8;

  localparam logic [SecWidth-1:0]   SecLimit   = SecWidth'(60);
  localparam logic [MinWidth-1:0]   MinLimit   = MinWidth'(60);
  localparam logic [HourWidth-1:0]  HourLimit  = HourWidth'(24);
  localparam logic [MonthWidth-1:0] MonthLimit = MonthWidth'(13);
  localparam logic [DayWidth:0]     DayPast    = (DayWidth + 1)'(32);

  localparam logic [MonthWidth-1:0] MonApr = MonthWidth'(4);
  localparam logic [MonthWidth-1:0] MonJun = MonthWidth'(6);
  localparam logic [MonthWidth-1:0] MonSep = MonthWidth'(9);
  localparam logic [MonthWidth-1:0] MonNov = MonthWidth'(11);
  localparam logic [MonthWidth-1:0] MonFeb = MonthWidth'(2);

  // year offsets that land on a century, and whether that century is leap
  localparam int  CentFirst = (100 - YearBase % 100) % 100;
  localparam logic [YearWidth-1:0] Cent0 = YearWidth'(CentFirst);
  localparam logic [YearWidth-1:0] Cent1 = YearWidth'(CentFirst + 100);
  localparam logic [YearWidth-1:0] Cent2 = YearWidth'(CentFirst + 200);
  localparam bit  Cent0Leap = ((YearBase + CentFirst) % 400) == 0;
  localparam bit  Cent1Leap = ((YearBase + CentFirst + 100) % 400) == 0;
  localparam bit  Cent2Leap = ((YearBase + CentFirst + 200) % 400) == 0;
  localparam logic [1:0] BaseMod4 = 2'(YearBase % 4);

  typedef struct packed {
    logic [YearWidth-1:0]  year;
    logic [MonthWidth-1:0] month;
    logic [DayWidth-1:0]   day;
    logic [HourWidth-1:0]  hour;
    logic [MinWidth-1:0]   min;
    logic [SecWidth-1:0]   sec;
  } cal_t;

  typedef enum logic [1:0] {
    REQ_TICK      = 2'd0,
    REQ_SET_TIME  = 2'd1,
    REQ_SET_ALARM = 2'd2,
    REQ_CLEAR     = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PAST  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  function automatic logic is_leap(input logic [YearWidth-1:0] year);
    logic div4;
    logic leap;
    div4 = (2'(year[1:0] + BaseMod4) == 2'd0);
    if (CalWidth > 0 && year == Cent0 && CentFirst < 256) begin
      leap = Cent0Leap;
    end else if (year == Cent1 && CentFirst + 100 < 256) begin
      leap = Cent1Leap;
    end else if (year == Cent2 && CentFirst + 200 < 256) begin
      leap = Cent2Leap;
    end else begin
      leap = div4;
    end
    return leap;
  endfunction

endpackage

FILE: sv/cca_advance.sv
module cca_advance (
  input  cca_pkg::cal_t cur,
  output cca_pkg::cal_t nxt
);

  logic [cca_pkg::SecWidth-1:0]   sec_inc;
  logic [cca_pkg::MinWidth-1:0]   min_inc;
  logic [cca_pkg::HourWidth-1:0]  hour_inc;
  logic [cca_pkg::DayWidth:0]     day_inc;
  logic [cca_pkg::MonthWidth-1:0] month_inc;
  logic                           month_end;

  assign sec_inc   = cur.sec + 1'b1;
  assign min_inc   = cur.min + 1'b1;
  assign hour_inc  = cur.hour + 1'b1;
  assign day_inc   = {1'b0, cur.day} + 1'b1;
  assign month_inc = cur.month + 1'b1;

  always_comb begin
    if (day_inc == cca_pkg::DayPast) begin
      month_end = 1'b1;
    end else if (day_inc == (cca_pkg::DayPast - 1'b1)) begin
      month_end = (cur.month == cca_pkg::MonApr) || (cur.month == cca_pkg::MonJun) ||
                  (cur.month == cca_pkg::MonSep) || (cur.month == cca_pkg::MonNov);
    end else if (day_inc == (cca_pkg::DayPast - 2'd2)) begin
      month_end = (cur.month == cca_pkg::MonFeb);
    end else if (day_inc == (cca_pkg::DayPast - 2'd3)) begin
      month_end = (cur.month == cca_pkg::MonFeb) && !cca_pkg::is_leap(cur.year);
    end else begin
      month_end = 1'b0;
    end
  end

  always_comb begin
    nxt     = cur;
    nxt.sec = sec_inc;
    if (sec_inc == cca_pkg::SecLimit) begin
      nxt.sec = '0;
      nxt.min = min_inc;
      if (min_inc == cca_pkg::MinLimit) begin
        nxt.min  = '0;
        nxt.hour = hour_inc;
        if (hour_inc == cca_pkg::HourLimit) begin
          nxt.hour = '0;
          if (month_end) begin
            nxt.day   = cca_pkg::DayWidth'(1);
            nxt.month = month_inc;
          end else begin
            nxt.day   = day_inc[cca_pkg::DayWidth-1:0];
          end
          if (nxt.month == cca_pkg::MonthLimit) begin
            nxt.month = cca_pkg::MonthWidth'(1);
            nxt.year  = cur.year + 1'b1;
          end
        end
      end
    end
  end

endmodule

FILE: sv/cca_alarm_check.sv
module cca_alarm_check (
  input  cca_pkg::cal_t    req,
  input  cca_pkg::cal_t    now,
  output cca_pkg::status_t status
);

  logic later;
  logic in_range;

  // packed order puts year in the top bits, so a plain compare is lexicographic
  assign later = req > now;

  assign in_range = (req.sec < cca_pkg::SecLimit) && (req.min < cca_pkg::MinLimit) &&
                    (req.hour < cca_pkg::HourLimit) && (req.day != '0) &&
                    (req.month != '0) && (req.month < cca_pkg::MonthLimit);

  always_comb begin
    if (!later) begin
      status = cca_pkg::ST_PAST;
    end else if (!in_range) begin
      status = cca_pkg::ST_RANGE;
    end else begin
      status = cca_pkg::ST_OK;
    end
  end

endmodule

FILE: sv/calendar_clock_with_alarm.sv
// Calendar clock with alarm. Each request on the input stream (tick, set time, set alarm,
// clear alarm, chosen by s_axis_tuser) gives exactly one result holding the time after the
// request, an alarm fired flag (ticks only), an alarm armed flag and a set-alarm status.
// A request is registered, worked by calendar and compare logic, and moves into the output
// register once the output side can take it; one request per cycle is sustained, limited
// only by the output side taking results. A tick that matches a nonzero alarm fires it
// and clears it. Years count from 1900 with Gregorian leap rules and wrap after 255.
module calendar_clock_with_alarm (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sec, min, hour, day, month, year, zero fill
  input  logic [cca_pkg::InDataWidth-1:0]      s_axis_tdata,
  // req_type
  input  logic [1:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // now_sec, now_min, now_hour, now_day, now_month, now_year, alarm_fired,
  // alarm_armed, status, zero fill
  output logic [cca_pkg::OutDataWidth-1:0]     m_axis_tdata
);

  logic                s1_valid;
  cca_pkg::req_kind_t  s1_req;
  cca_pkg::cal_t       s1_cal;
  logic                s1_move;

  cca_pkg::cal_t       now_cal;
  cca_pkg::cal_t       now_cal_next;
  cca_pkg::cal_t       alarm_cal;
  cca_pkg::cal_t       alarm_cal_next;
  cca_pkg::cal_t       adv_cal;
  cca_pkg::status_t    chk_status;
  cca_pkg::status_t    status_next;
  logic                fired_next;
  logic                armed_next;

  assign s1_move       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_req <= cca_pkg::req_kind_t'(s_axis_tuser);
      s1_cal <= s_axis_tdata[cca_pkg::CalWidth-1:0];
    end
  end

  cca_advance u_advance (
    .cur (now_cal),
    .nxt (adv_cal)
  );

  cca_alarm_check u_alarm_check (
    .req    (s1_cal),
    .now    (now_cal),
    .status (chk_status)
  );

  always_comb begin
    now_cal_next   = now_cal;
    alarm_cal_next = alarm_cal;
    fired_next     = 1'b0;
    status_next    = cca_pkg::ST_OK;
    unique case (s1_req)
      cca_pkg::REQ_TICK: begin
        now_cal_next = adv_cal;
        if ((alarm_cal != '0) && (adv_cal == alarm_cal)) begin
          fired_next     = 1'b1;
          alarm_cal_next = '0;
        end
      end
      cca_pkg::REQ_SET_TIME: begin
        now_cal_next = s1_cal;
      end
      cca_pkg::REQ_SET_ALARM: begin
        status_next = chk_status;
        if (chk_status == cca_pkg::ST_OK) begin
          alarm_cal_next = s1_cal;
        end
      end
      cca_pkg::REQ_CLEAR: begin
        alarm_cal_next = '0;
      end
      default: begin
        now_cal_next = now_cal;
      end
    endcase
  end

  assign armed_next = (alarm_cal_next != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      now_cal   <= '0;
      alarm_cal <= '0;
    end else if (s1_move) begin
      now_cal   <= now_cal_next;
      alarm_cal <= alarm_cal_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_axis_tdata <= {(cca_pkg::OutDataWidth - cca_pkg::OutBits)'(0), status_next,
                       armed_next, fired_next, now_cal_next};
    end
  end

endmodule

FILE: bench/tb_calendar_clock_with_alarm.sv
`timescale 1ns / 1ps

module tb_calendar_clock_with_alarm;
  import cca_pkg::*;

  localparam int RandomItems   = 800;
  localparam int WatchdogLimit = 2000;
  localparam int TailCycles    = 8;
  localparam int PrintCap      = 40;

  typedef struct packed {
    status_t status;
    logic    armed;
    logic    fired;
    cal_t    now;
  } rtc_result_t;

  typedef struct {
    req_kind_t   req;
    cal_t        t;
    bit          typed;
    rtc_result_t want;
  } drive_row_t;

  logic                    clk;
  logic                    rst;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata;
  logic [1:0]              s_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OutDataWidth-1:0] m_axis_tdata;

  // typed expectation that rides along with the current request
  logic        row_typed;
  rtc_result_t row_want;

  cal_t        clock_now   = '0;
  cal_t        clock_alarm = '0;
  rtc_result_t pending_results[$];
  drive_row_t  directed[$];
  int          errors      = 0;
  int          idle_cycles = 0;
  int          sent        = 0;
  int          burst_left  = 0;

  calendar_clock_with_alarm uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit leap_year(logic [YearWidth-1:0] y);
    int full;
    full = int'(y) + YearBase;
    return (full % 400 == 0) || (full % 4 == 0 && full % 100 != 0);
  endfunction

  function automatic cal_t tick_once(cal_t t);
    logic [DayWidth:0] d;
    bit                month_end;
    t.sec = t.sec + 1'b1;
    if (t.sec != SecLimit) return t;
    t.sec = '0;
    t.min = t.min + 1'b1;
    if (t.min != MinLimit) return t;
    t.min  = '0;
    t.hour = t.hour + 1'b1;
    if (t.hour != HourLimit) return t;
    t.hour    = '0;
    d         = {1'b0, t.day} + 1'b1;
    month_end = 1'b0;
    if (d == DayPast) begin
      month_end = 1'b1;
    end else if (d == (DayPast - 1'b1)) begin
      month_end = (t.month == MonApr) || (t.month == MonJun) ||
                  (t.month == MonSep) || (t.month == MonNov);
    end else if (d == (DayPast - 2'd2)) begin
      month_end = (t.month == MonFeb);
    end else if (d == (DayPast - 2'd3)) begin
      month_end = (t.month == MonFeb) && !leap_year(t.year);
    end
    if (month_end) begin
      d       = (DayWidth + 1)'(1);
      t.month = t.month + 1'b1;
    end
    t.day = d[DayWidth-1:0];
    if (t.month == MonthLimit) begin
      t.month = MonthWidth'(1);
      t.year  = t.year + 1'b1;
    end
    return t;
  endfunction

  function automatic rtc_result_t rtc_apply(req_kind_t req, cal_t t);
    rtc_result_t r;
    r.fired  = 1'b0;
    r.status = ST_OK;
    case (req)
      REQ_TICK: begin
        clock_now = tick_once(clock_now);
        if (clock_alarm != '0 && clock_now == clock_alarm) begin
          r.fired     = 1'b1;
          clock_alarm = '0;
        end
      end
      REQ_SET_TIME: begin
        clock_now = t;
      end
      REQ_SET_ALARM: begin
        // packed order is year down to sec, so this is the tuple compare
        if (!(t > clock_now)) begin
          r.status = ST_PAST;
        end else if (t.sec < SecLimit && t.min < MinLimit && t.hour < HourLimit &&
                     t.day != '0 && t.month != '0 && t.month < MonthLimit) begin
          clock_alarm = t;
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: begin
        clock_alarm = '0;
      end
    endcase
    r.now   = clock_now;
    r.armed = (clock_alarm != '0);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= PrintCap) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic cal_t cal_of(int y, int mo, int d, int h, int mi, int s);
    cal_t c;
    c.year  = YearWidth'(y);
    c.month = MonthWidth'(mo);
    c.day   = DayWidth'(d);
    c.hour  = HourWidth'(h);
    c.min   = MinWidth'(mi);
    c.sec   = SecWidth'(s);
    return c;
  endfunction

  function automatic rtc_result_t res_of(cal_t n, bit fired, bit armed, status_t st);
    rtc_result_t r;
    r.now    = n;
    r.fired  = fired;
    r.armed  = armed;
    r.status = st;
    return r;
  endfunction

  function automatic cal_t rand_cal();
    logic [63:0] raw;
    cal_t        c;
    raw = {$urandom(), $urandom()};
    c   = raw[CalWidth-1:0];
    return c;
  endfunction

  // times close to second, minute, hour, day, month and year rollovers
  function automatic cal_t edge_time();
    cal_t c;
    c.sec  = SecWidth'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) :
                                                      $urandom_range(50, 59));
    c.min  = MinWidth'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : 59);
    c.hour = HourWidth'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : 23);
    c.day  = DayWidth'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) :
                                                      $urandom_range(27, 31));
    case ($urandom_range(0, 7))
      0:       c.month = MonthWidth'($urandom_range(0, 15));
      1, 2:    c.month = MonFeb;
      default: c.month = MonthWidth'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 7))
      0:       c.year = YearWidth'(0);
      1:       c.year = YearWidth'(100);
      2:       c.year = YearWidth'(200);
      3:       c.year = YearWidth'(255);
      4:       c.year = YearWidth'(4 * $urandom_range(0, 63));
      default: c.year = YearWidth'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_row(req_kind_t req, cal_t t);
    drive_row_t row;
    row.req   = req;
    row.t     = t;
    row.typed = 1'b0;
    row.want  = '0;
    directed.push_back(row);
  endtask

  task automatic add_typed(req_kind_t req, cal_t t, rtc_result_t want);
    drive_row_t row;
    row.req   = req;
    row.t     = t;
    row.typed = 1'b1;
    row.want  = want;
    directed.push_back(row);
  endtask

  task automatic send_row(drive_row_t row);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = pick_pause();
      if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(40, 150);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataWidth'(row.t);
    s_axis_tuser  <= row.req;
    row_typed     <= row.typed;
    row_want      <= row.want;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_req(req_kind_t req, cal_t t);
    drive_row_t row;
    row.req   = req;
    row.t     = t;
    row.typed = 1'b0;
    row.want  = '0;
    send_row(row);
  endtask

  // input side transfer: advance the predictor
  always @(posedge clk) begin
    rtc_result_t pred;
    cal_t        req_t;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      req_t = s_axis_tdata[CalWidth-1:0];
      pred  = rtc_apply(req_kind_t'(s_axis_tuser), req_t);
      pending_results.push_back(row_typed ? row_want : pred);
    end
  end

  // output side transfer: compare with the oldest pending result
  always @(posedge clk) begin
    rtc_result_t got;
    rtc_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[OutBits-1:0];
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending");
      end else begin
        want = pending_results.pop_front();
        check_field("sec", int'(got.now.sec), int'(want.now.sec));
        check_field("min", int'(got.now.min), int'(want.now.min));
        check_field("hour", int'(got.now.hour), int'(want.now.hour));
        check_field("day", int'(got.now.day), int'(want.now.day));
        check_field("month", int'(got.now.month), int'(want.now.month));
        check_field("year", int'(got.now.year), int'(want.now.year));
        check_field("alarm_fired", int'(got.fired), int'(want.fired));
        check_field("alarm_armed", int'(got.armed), int'(want.armed));
        check_field("status", int'(got.status), int'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("calendar_clock_with_alarm verification failed");
      $finish;
    end
  end

  // output side backpressure
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(100, 300)) @(posedge clk);
      end else begin
        stall = pick_pause();
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    cal_t top;
    cal_t plan;
    cal_t target;
    int   k;
    int   pick;
    bit   drained;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_TICK;
    row_typed     <= 1'b0;
    row_want      <= '0;
    drained       = 1'b0;
    top           = cal_of(255, 15, 31, 31, 63, 63);

    add_typed(REQ_TICK, top, res_of(cal_of(0, 0, 0, 0, 0, 1), 1'b0, 1'b0, ST_OK));
    add_typed(REQ_SET_ALARM, '0, res_of(cal_of(0, 0, 0, 0, 0, 1), 1'b0, 1'b0, ST_PAST));
    add_typed(REQ_SET_ALARM, top, res_of(cal_of(0, 0, 0, 0, 0, 1), 1'b0, 1'b0, ST_RANGE));
    add_typed(REQ_SET_TIME, top, res_of(top, 1'b0, 1'b0, ST_OK));
    // out of range seconds wrap without carry
    add_typed(REQ_TICK, '0, res_of(cal_of(255, 15, 31, 31, 63, 0), 1'b0, 1'b0, ST_OK));
    add_typed(REQ_SET_TIME, cal_of(255, 12, 31, 23, 59, 58),
              res_of(cal_of(255, 12, 31, 23, 59, 58), 1'b0, 1'b0, ST_OK));
    add_row(REQ_SET_ALARM, cal_of(255, 12, 31, 23, 59, 59));
    add_row(REQ_TICK, '0);
    // year wrap
    add_typed(REQ_TICK, '0, res_of(cal_of(0, 1, 1, 0, 0, 0), 1'b0, 1'b0, ST_OK));
    // leap and common february ends, 30 day month end
    add_row(REQ_SET_TIME, cal_of(100, 2, 28, 23, 59, 59));
    add_row(REQ_TICK, '0);
    add_row(REQ_SET_TIME, cal_of(0, 2, 28, 23, 59, 59));
    add_row(REQ_TICK, '0);
    add_row(REQ_SET_TIME, cal_of(104, 2, 29, 23, 59, 59));
    add_row(REQ_TICK, '0);
    add_row(REQ_SET_TIME, cal_of(5, 4, 30, 23, 59, 59));
    add_row(REQ_TICK, '0);
    // all zero time against the unarmed alarm
    add_row(REQ_SET_TIME, cal_of(0, 0, 0, 0, 0, 63));
    add_typed(REQ_TICK, '0, res_of('0, 1'b0, 1'b0, ST_OK));
    add_row(REQ_SET_TIME, cal_of(10, 3, 5, 12, 0, 0));
    add_row(REQ_SET_ALARM, cal_of(10, 3, 5, 12, 0, 0));
    add_row(REQ_SET_ALARM, cal_of(11, 1, 0, 0, 0, 0));
    add_row(REQ_SET_ALARM, cal_of(10, 3, 5, 12, 0, 1));
    add_row(REQ_CLEAR, top);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_row(directed[i]);

    while (sent < directed.size() + RandomItems) begin
      if (!drained && sent >= directed.size() + RandomItems / 2) begin
        drained = 1'b1;
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        plan = edge_time();
        send_req(REQ_SET_TIME, plan);
        target = plan;
        pick   = $urandom_range(0, 9);
        if (pick < 6) begin
          k = $urandom_range(1, 6);
          repeat (k) target = tick_once(target);
          send_req(REQ_SET_ALARM, target);
          if (pick == 0) send_req(REQ_CLEAR, rand_cal());
          k = k + $urandom_range(0, 3);
        end else if (pick < 8) begin
          if ($urandom_range(0, 1)) target = rand_cal();
          send_req(REQ_SET_ALARM, target);
          k = $urandom_range(1, 8);
        end else begin
          target.year = plan.year + 1'b1;
          case ($urandom_range(0, 4))
            0: target.sec = SecWidth'($urandom_range(60, 63));
            1: target.min = MinWidth'($urandom_range(60, 63));
            2: target.hour = HourWidth'($urandom_range(24, 31));
            3: target.day = '0;
            default: target.month = MonthWidth'($urandom_range(0, 1) ? 0 :
                                                 $urandom_range(13, 15));
          endcase
          send_req(REQ_SET_ALARM, target);
          k = $urandom_range(1, 8);
        end
        if ($urandom_range(0, 9) == 0) k = k + $urandom_range(30, 120);
        repeat (k) send_req(REQ_TICK, rand_cal());
      end else begin
        repeat ($urandom_range(1, 5)) send_req(req_kind_t'($urandom_range(0, 3)), rand_cal());
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (TailCycles) @(posedge clk);
    if (errors == 0) begin
      $display("calendar_clock_with_alarm verification clean");
    end else begin
      $display("calendar_clock_with_alarm verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/cca_pkg.sv
sv/cca_advance.sv
sv/cca_alarm_check.sv
sv/calendar_clock_with_alarm.sv
bench/tb_calendar_clock_with_alarm.sv
